// ===== rtl/core/utrdc_pkg.sv =====
// Shared types, codes and defaults for the UART transmit ring chunker.
package utrdc_pkg;

  localparam int unsigned RING_DEPTH_DEF = 4096;
  localparam int unsigned CHUNK_MAX_DEF  = 512;

  localparam int unsigned ACT_W  = 3;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 10;
  localparam int unsigned PEND_W = 12;
  localparam int unsigned CNT_W  = 32;

  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE   = 3'd0,
    ACT_PULL    = 3'd1,
    ACT_DONE    = 3'd2,
    ACT_ERROR   = 3'd3,
    ACT_REFUSED = 3'd4
  } action_e;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [BYTE_W-1:0] write_byte;
    logic              message_end;
  } item_t;

  typedef struct packed {
    logic              accepted;
    logic              launch;
    logic [LEN_W-1:0]  launch_length;
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_byte;
    logic [PEND_W-1:0] pending;
    logic [CNT_W-1:0]  overflow_total;
    logic [CNT_W-1:0]  failure_total;
  } res_t;

endpackage

// ===== rtl/core/utrdc_item_if.sv =====
// Input word channel: action, byte and message end with valid/ready.
interface utrdc_item_if
  import utrdc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [BYTE_W-1:0] write_byte;
  logic              message_end;

  modport source (output valid, action, write_byte, message_end, input ready);
  modport sink   (input valid, action, write_byte, message_end, output ready);
endinterface

// ===== rtl/core/utrdc_result_if.sv =====
// Result word channel: status of one processed input word with valid/ready.
interface utrdc_result_if
  import utrdc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              accepted;
  logic              launch;
  logic [LEN_W-1:0]  launch_length;
  logic              tx_valid;
  logic [BYTE_W-1:0] tx_byte;
  logic [PEND_W-1:0] pending;
  logic [CNT_W-1:0]  overflow_total;
  logic [CNT_W-1:0]  failure_total;

  modport source (output valid, accepted, launch, launch_length, tx_valid, tx_byte,
                  pending, overflow_total, failure_total, input ready);
  modport sink   (input valid, accepted, launch, launch_length, tx_valid, tx_byte,
                  pending, overflow_total, failure_total, output ready);
endinterface

// ===== rtl/core/utrdc_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
module utrdc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/utrdc_core.sv =====
// Ring pointers, chunk state and counters; updates once per accepted word.
module utrdc_core
  import utrdc_pkg::*;
#(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF,
  parameter int unsigned CHUNK_MAX  = CHUNK_MAX_DEF,
  localparam int unsigned PW        = $clog2(RING_DEPTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  item_t             item_i,
  output res_t              res_o,
  output logic              ram_we_o,
  output logic [PW-1:0]     ram_waddr_o,
  output logic [BYTE_W-1:0] ram_wdata_o,
  output logic              ram_re_o,
  output logic [PW-1:0]     ram_raddr_o
);

  localparam int unsigned CW = (CHUNK_MAX > 1) ? $clog2(CHUNK_MAX + 1) : 1;
  localparam int unsigned MW = (PW > CW) ? PW : CW;
  localparam int unsigned SW = MW + 1;
  localparam logic [SW-1:0] DEPTH_S  = SW'(RING_DEPTH);
  localparam logic [PW:0]   DEPTH_Q  = (PW + 1)'(RING_DEPTH);
  localparam logic [PW-1:0] LAST_POS = PW'(RING_DEPTH - 1);
  localparam logic [MW-1:0] CMAX_M   = MW'(CHUNK_MAX);

  logic [PW-1:0]    wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0]    clen_q, clen_d, sent_q, sent_d;
  logic             busy_q, busy_d, drop_q, drop_d;
  logic [CNT_W-1:0] ovf_q, ovf_d, fail_q, fail_d;

  logic [PW-1:0] wp_inc, wp_n, rp_n, rp_adv, rd_pos;
  logic          full, try_l, busy_mid, launch;
  logic [CW-1:0] clen_mid, n_len;
  logic [PW-1:0] q_n;
  logic [MW-1:0] q_m;

  // Position plus offset, wrapped once; offset never reaches the depth.
  function automatic logic [PW-1:0] adv(input logic [PW-1:0] pos, input logic [CW-1:0] by);
    logic [SW-1:0] s;
    s = SW'(pos) + SW'(by);
    if (s >= DEPTH_S) begin
      s = s - DEPTH_S;
    end
    return PW'(s);
  endfunction

  function automatic logic [PW-1:0] fill(input logic [PW-1:0] w, input logic [PW-1:0] r);
    logic [PW:0] d;
    d = {1'b0, w} - {1'b0, r};
    if (w < r) begin
      d = d + DEPTH_Q;
    end
    return PW'(d);
  endfunction

  assign wp_inc = (wp_q == LAST_POS) ? '0 : wp_q + 1'b1;
  assign full   = (wp_inc == rp_q);
  assign rp_adv = adv(rp_q, clen_q);
  assign rd_pos = adv(rp_q, sent_q);

  always_comb begin
    wp_d     = wp_q;
    drop_d   = drop_q;
    ovf_d    = ovf_q;
    fail_d   = fail_q;
    sent_d   = sent_q;
    wp_n     = wp_q;
    rp_n     = rp_q;
    busy_mid = busy_q;
    clen_mid = clen_q;
    try_l    = 1'b0;
    ram_we_o = 1'b0;
    ram_re_o = 1'b0;
    res_o    = '0;

    case (action_e'(item_i.action))
      ACT_WRITE: begin
        if (drop_q) begin
          if (item_i.message_end) begin
            drop_d = 1'b0;
          end
        end else if (full) begin
          ovf_d  = ovf_q + 1'b1;
          drop_d = !item_i.message_end;
          try_l  = 1'b1;
        end else begin
          ram_we_o       = step_i;
          wp_n           = wp_inc;
          res_o.accepted = 1'b1;
          try_l          = item_i.message_end;
        end
      end
      ACT_PULL: begin
        if (busy_q && (sent_q < clen_q)) begin
          ram_re_o       = step_i;
          sent_d         = sent_q + 1'b1;
          res_o.tx_valid = 1'b1;
        end
      end
      ACT_DONE: begin
        rp_n     = rp_adv;
        busy_mid = 1'b0;
        clen_mid = '0;
        sent_d   = '0;
        try_l    = 1'b1;
      end
      ACT_ERROR: begin
        fail_d   = fail_q + 1'b1;
        busy_mid = 1'b0;
        clen_mid = '0;
        sent_d   = '0;
        try_l    = 1'b1;
      end
      ACT_REFUSED: begin
        fail_d   = fail_q + 1'b1;
        busy_mid = 1'b0;
        clen_mid = '0;
        sent_d   = '0;
      end
      default: begin
      end
    endcase

    wp_d = wp_n;
    rp_d = rp_n;

    // Launch sizing: min(pending after the word, chunk limit).
    q_n    = fill(wp_n, rp_n);
    q_m    = MW'(q_n);
    n_len  = CW'((q_m > CMAX_M) ? CMAX_M : q_m);
    launch = try_l && !busy_mid && (q_n != '0);

    busy_d = launch ? 1'b1 : busy_mid;
    clen_d = launch ? n_len : clen_mid;
    if (launch) begin
      sent_d = '0;
    end

    res_o.launch         = launch;
    res_o.launch_length  = launch ? LEN_W'(n_len) : '0;
    res_o.pending        = PEND_W'(q_n);
    res_o.overflow_total = ovf_d;
    res_o.failure_total  = fail_d;
  end

  assign ram_waddr_o = wp_q;
  assign ram_wdata_o = item_i.write_byte;
  assign ram_raddr_o = rd_pos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      rp_q   <= '0;
      clen_q <= '0;
      sent_q <= '0;
      busy_q <= 1'b0;
      drop_q <= 1'b0;
      ovf_q  <= '0;
      fail_q <= '0;
    end else if (step_i) begin
      wp_q   <= wp_d;
      rp_q   <= rp_d;
      clen_q <= clen_d;
      sent_q <= sent_d;
      busy_q <= busy_d;
      drop_q <= drop_d;
      ovf_q  <= ovf_d;
      fail_q <= fail_d;
    end
  end

endmodule

// ===== rtl/core/uart_tx_ring_dma_chunker.sv =====
// Top level of the UART transmit ring with chunked DMA hand-off.
//
// Usage:
//  - item_i carries one word per handshake: action (write, pull, complete,
//    error, refused), write_byte and message_end.
//  - result_o returns exactly one word per input word, in order: accepted,
//    launch/launch_length, tx_valid/tx_byte, pending and both counters.
//  - Bytes live in a RING_DEPTH x 8 synchronous RAM; one slot stays empty,
//    so at most RING_DEPTH-1 bytes wait. Chunks are min(pending, CHUNK_MAX).
//  - A result is registered in the cycle after its word is taken.
//    A pull that returns a byte waits for the RAM read in ST_READ, so its
//    result is registered only after that state.
//  - Throughput: one word per cycle while the receiver keeps up; a pull
//    that returns a byte holds the input while ST_READ waits on the RAM.
//  - The output register lets the next word be taken in the same cycle a
//    waiting result leaves. If the receiver stalls, the result holds and
//    item_i.ready drops until the result is taken.
//  - Reset (rst_ni low, async) clears pointers, chunk state, drop flag and
//    both counters. The RAM is not cleared; no entry is read before it is
//    written.
module uart_tx_ring_dma_chunker
  import utrdc_pkg::*;
#(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF,
  parameter int unsigned CHUNK_MAX  = CHUNK_MAX_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  utrdc_item_if.sink     item_i,
  utrdc_result_if.source result_o
);

  localparam int unsigned PW = $clog2(RING_DEPTH);

  state_e  state_q, state_d;
  res_t    res_q, res_d, core_res;
  logic    out_valid_q, out_valid_d;
  logic    in_ready, step;
  item_t   item;

  logic              ram_we, ram_re;
  logic [PW-1:0]     ram_waddr, ram_raddr;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata;

  assign item.action      = item_i.action;
  assign item.write_byte  = item_i.write_byte;
  assign item.message_end = item_i.message_end;

  // Take a word when not waiting on the RAM and the output slot frees up.
  assign in_ready     = (state_q == ST_IDLE) && (!out_valid_q || result_o.ready);
  assign item_i.ready = in_ready;
  assign step         = item_i.valid && in_ready;

  utrdc_core #(
    .RING_DEPTH (RING_DEPTH),
    .CHUNK_MAX  (CHUNK_MAX)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (item),
    .res_o       (core_res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr)
  );

  utrdc_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Output slot and pull read wait.
  always_comb begin
    state_d     = state_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && result_o.ready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (step) begin
          res_d = core_res;
          if (core_res.tx_valid) begin
            state_d = ST_READ;      // byte arrives from RAM next cycle
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      ST_READ: begin
        res_d.tx_byte = ram_rdata;
        out_valid_d   = 1'b1;
        state_d       = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.accepted       = res_q.accepted;
  assign result_o.launch         = res_q.launch;
  assign result_o.launch_length  = res_q.launch_length;
  assign result_o.tx_valid       = res_q.tx_valid;
  assign result_o.tx_byte        = res_q.tx_byte;
  assign result_o.pending        = res_q.pending;
  assign result_o.overflow_total = res_q.overflow_total;
  assign result_o.failure_total  = res_q.failure_total;

endmodule

// ===== rtl/core/utrdc_checker.sv =====
// Port-level checks on the result channel, bound to the top level.
module utrdc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        accepted_i,
  input logic        launch_i,
  input logic [9:0]  launch_length_i,
  input logic        tx_valid_i,
  input logic [31:0] failure_total_i
);

  logic        seen_q;
  logic [31:0] last_fail_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= 1'b0;
      last_fail_q <= '0;
    end else if (out_valid_i && out_ready_i) begin
      seen_q      <= 1'b1;
      last_fail_q <= failure_total_i;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(failure_total_i))
    else $error("result word dropped or changed while stalled");

  a_len_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !launch_i |-> launch_length_i == 10'd0)
    else $error("launch length without launch");

  a_pull_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && tx_valid_i |-> !accepted_i && !launch_i)
    else $error("pulled byte mixed with write or launch");

  a_fail_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && seen_q |->
      (failure_total_i == last_fail_q) || (failure_total_i == last_fail_q + 32'd1))
    else $error("failure count jumped");

endmodule

bind uart_tx_ring_dma_chunker utrdc_checker u_utrdc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (result_o.valid),
  .out_ready_i     (result_o.ready),
  .accepted_i      (result_o.accepted),
  .launch_i        (result_o.launch),
  .launch_length_i (result_o.launch_length),
  .tx_valid_i      (result_o.tx_valid),
  .failure_total_i (result_o.failure_total)
);

// ===== test/utrdc_tb_pkg.sv =====
// Status predictor and checker class for the transmit ring chunker testbench.
package utrdc_tb_pkg;
  import utrdc_pkg::*;

  class tx_ring_checker;
    logic [BYTE_W-1:0] ring_bytes [RING_DEPTH_DEF];
    int unsigned       wr_pos;
    int unsigned       rd_pos;
    bit [LEN_W-1:0]    chunk_len;
    bit [LEN_W-1:0]    chunk_sent;
    bit                busy;
    bit                dropping;
    bit [CNT_W-1:0]    overflow_cnt;
    bit [CNT_W-1:0]    fail_cnt;

    res_t        status_q [$];
    int unsigned words_noted;
    int unsigned words_checked;
    int unsigned mismatches;
    int unsigned launches;
    int unsigned bytes_pulled;

    function int unsigned queued_bytes();
      if (wr_pos >= rd_pos) return wr_pos - rd_pos;
      return RING_DEPTH_DEF - (rd_pos - wr_pos);
    endfunction

    function void drop_chunk();
      busy       = 1'b0;
      chunk_len  = '0;
      chunk_sent = '0;
    endfunction

    // Starts a chunk when idle and bytes wait; returns its length or zero.
    function bit [LEN_W-1:0] start_chunk();
      int unsigned n;
      if (busy) return '0;
      n = queued_bytes();
      if (n > CHUNK_MAX_DEF) n = CHUNK_MAX_DEF;
      if (n == 0) return '0;
      busy       = 1'b1;
      chunk_len  = LEN_W'(n);
      chunk_sent = '0;
      launches++;
      return LEN_W'(n);
    endfunction

    function res_t next_status(item_t w);
      res_t        r;
      int unsigned nxt;
      r = '0;
      case (w.action)
        ACT_WRITE: begin
          if (dropping) begin
            if (w.message_end) dropping = 1'b0;
          end else begin
            nxt = (wr_pos + 1) % RING_DEPTH_DEF;
            if (nxt == rd_pos) begin
              overflow_cnt++;
              dropping        = !w.message_end;
              r.launch_length = start_chunk();
            end else begin
              ring_bytes[wr_pos] = w.write_byte;
              wr_pos             = nxt;
              r.accepted         = 1'b1;
              if (w.message_end) r.launch_length = start_chunk();
            end
          end
        end
        ACT_PULL: begin
          if (busy && chunk_sent < chunk_len) begin
            r.tx_byte  = ring_bytes[(rd_pos + chunk_sent) % RING_DEPTH_DEF];
            r.tx_valid = 1'b1;
            chunk_sent++;
            bytes_pulled++;
          end
        end
        ACT_DONE: begin
          rd_pos = (rd_pos + chunk_len) % RING_DEPTH_DEF;
          drop_chunk();
          r.launch_length = start_chunk();
        end
        ACT_ERROR: begin
          fail_cnt++;
          drop_chunk();
          r.launch_length = start_chunk();
        end
        ACT_REFUSED: begin
          fail_cnt++;
          drop_chunk();
        end
        default: ;
      endcase
      r.launch         = (r.launch_length != '0);
      r.pending        = PEND_W'(queued_bytes());
      r.overflow_total = overflow_cnt;
      r.failure_total  = fail_cnt;
      return r;
    endfunction

    function void note_word(item_t w);
      status_q.push_back(next_status(w));
      words_noted++;
    endfunction

    function void check_word(res_t got);
      res_t exp;
      bit   bad;
      words_checked++;
      if (status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected status word %p", $time, got);
        return;
      end
      exp = status_q.pop_front();
      bad = (got.accepted       !== exp.accepted)      ||
            (got.launch         !== exp.launch)        ||
            (got.launch_length  !== exp.launch_length) ||
            (got.tx_valid       !== exp.tx_valid)      ||
            (got.tx_byte        !== exp.tx_byte)       ||
            (got.pending        !== exp.pending)       ||
            (got.overflow_total !== exp.overflow_total) ||
            (got.failure_total  !== exp.failure_total);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] status word %0d mismatch", $time, words_checked);
          $display("  expected %p", exp);
          $display("  actual   %p", got);
        end
      end
    endfunction
  endclass

endpackage

// ===== test/tb_top.sv =====
// Top-level testbench of the transmit ring chunker: stimulus, result sink and checks.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import utrdc_pkg::*;
  import utrdc_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned HOLD_AFTER  = 400;  // results seen before the long stall
  localparam int unsigned HOLD_CYCLES = 300;  // length of the long receiver stall
  localparam int unsigned DRAIN_WAIT  = 10;   // settling wait after the last result is checked

  logic clk_i;
  logic rst_ni;

  utrdc_item_if   item_if ();
  utrdc_result_if result_if ();

  uart_tx_ring_dma_chunker u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (result_if)
  );

  tx_ring_checker board = new();

  int          msg_left;     // bytes left in the message being written
  bit          burst_mode;   // both sides run with no idle cycles
  bit          hold_done;
  int unsigned cycle_count;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d status words outstanding",
             cycle_count, board.status_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic item_t word_of(logic [ACT_W-1:0] act, logic [BYTE_W-1:0] data,
                                    logic last);
    item_t w;
    w.action      = act;
    w.write_byte  = data;
    w.message_end = last;
    return w;
  endfunction

  // Offers one word after a random gap; drives at negedge, samples at posedge.
  // Valid is only lowered when a gap follows, so back-to-back words keep it high.
  task automatic send_word(input item_t w);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 10);
    @(negedge clk_i);
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    item_if.valid       <= 1'b1;
    item_if.action      <= w.action;
    item_if.write_byte  <= w.write_byte;
    item_if.message_end <= w.message_end;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    board.note_word(w);
  endtask

  // Control words carry random byte and end bits; the block must ignore them.
  task automatic send_ctrl(input logic [ACT_W-1:0] act);
    send_word(word_of(act, 8'($urandom), 1'($urandom)));
  endtask

  // Next byte of a well-formed message; mostly short, sometimes past a chunk.
  task automatic send_message_byte();
    int pick;
    if (msg_left == 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)      msg_left = $urandom_range(1, 8);
      else if (pick < 95) msg_left = $urandom_range(9, 64);
      else                msg_left = $urandom_range(65, 700);
    end
    msg_left--;
    send_word(word_of(ACT_WRITE, 8'($urandom), msg_left == 0));
  endtask

  // Noise: undefined action codes or a message cut short by a stray end.
  task automatic send_noise();
    if ($urandom_range(0, 1) == 0) begin
      send_ctrl(3'($urandom_range(5, 7)));
    end else begin
      msg_left = 0;
      send_word(word_of(ACT_WRITE, 8'($urandom), 1'b1));
    end
  endtask

  // Short directed walk over idle corner cases, resend, refusal and retire.
  task automatic run_directed();
    send_ctrl(ACT_PULL);                               // pull with nothing in flight
    send_ctrl(ACT_DONE);                               // complete while idle
    send_ctrl(ACT_ERROR);                              // error while idle, nothing queued
    send_ctrl(ACT_REFUSED);                            // refusal while idle
    send_ctrl(3'd5);                                   // undefined action codes
    send_ctrl(3'd6);
    send_ctrl(3'd7);
    send_word(word_of(ACT_WRITE, 8'h00, 1'b0));        // no launch before message end
    send_word(word_of(ACT_WRITE, 8'hFF, 1'b1));        // launches a 2-byte chunk
    send_word(word_of(ACT_WRITE, 8'hA5, 1'b1));        // queued behind busy sender
    send_ctrl(ACT_PULL);
    send_ctrl(ACT_PULL);
    send_ctrl(ACT_PULL);                               // chunk used up
    send_ctrl(ACT_ERROR);                              // resend, now 3 bytes
    send_ctrl(ACT_PULL);
    send_ctrl(ACT_REFUSED);                            // sender idle, nothing retired
    send_ctrl(ACT_PULL);
    send_ctrl(ACT_DONE);                               // retires 0, relaunches 3
    repeat (3) send_ctrl(ACT_PULL);
    send_ctrl(ACT_DONE);                               // ring empty again
    send_word(word_of(ACT_WRITE, 8'h5A, 1'b1));
    send_ctrl(ACT_DONE);
  endtask

  // Transmitter-like traffic: weights follow the predicted sender state.
  task automatic run_traffic(input int count);
    int pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (board.busy && board.chunk_sent < board.chunk_len) begin
        if (pick < 60)      send_ctrl(ACT_PULL);
        else if (pick < 85) send_message_byte();
        else if (pick < 92) send_ctrl(ACT_DONE);      // early complete
        else if (pick < 96) send_ctrl(ACT_ERROR);
        else if (pick < 98) send_ctrl(ACT_REFUSED);
        else                send_noise();
      end else if (board.busy) begin
        if (pick < 60)      send_ctrl(ACT_DONE);
        else if (pick < 72) send_ctrl(ACT_ERROR);
        else if (pick < 78) send_ctrl(ACT_REFUSED);
        else if (pick < 93) send_message_byte();
        else if (pick < 97) send_ctrl(ACT_PULL);      // pull past chunk end
        else                send_noise();
      end else begin
        if (pick < 85)      send_message_byte();
        else if (pick < 89) send_ctrl(ACT_PULL);
        else if (pick < 92) send_ctrl(ACT_DONE);
        else if (pick < 95) send_ctrl(ACT_ERROR);
        else if (pick < 97) send_ctrl(ACT_REFUSED);
        else                send_noise();
      end
    end
  endtask

  // Fill to one slot short of depth without retiring, then hit the full ring.
  task automatic fill_until_full();
    while (board.queued_bytes() < RING_DEPTH_DEF - 1)
      send_word(word_of(ACT_WRITE, 8'($urandom), $urandom_range(0, 63) == 0));
    send_word(word_of(ACT_WRITE, 8'($urandom), 1'b0));  // overflow, rest of message dropped
    send_word(word_of(ACT_WRITE, 8'($urandom), 1'b0));  // silently dropped
    send_word(word_of(ACT_WRITE, 8'($urandom), 1'b1));  // dropped, ends the message
    send_word(word_of(ACT_WRITE, 8'($urandom), 1'b1));  // overflow on a last byte
    send_ctrl(ACT_REFUSED);
    send_word(word_of(ACT_WRITE, 8'($urandom), 1'b1));  // overflow launches a full chunk
    repeat (40) send_word(word_of(ACT_WRITE, 8'($urandom), 1'($urandom)));
    send_word(word_of(ACT_WRITE, 8'($urandom), 1'b1));  // leave no message open
    msg_left = 0;
  endtask

  // Empty the ring chunk by chunk; a few pulls each, then retire.
  task automatic drain_ring();
    while (board.queued_bytes() > 0) begin
      if (!board.busy) begin
        send_ctrl(ACT_ERROR);
      end else begin
        repeat ($urandom_range(0, 24)) send_ctrl(ACT_PULL);
        send_ctrl(ACT_DONE);
      end
    end
  endtask

  // Result sink: random ready gaps, one long stall once the run is under way.
  initial begin : result_sink
    int   gap;
    res_t got;
    @(posedge rst_ni);
    forever begin
      if (!hold_done && board.words_checked >= HOLD_AFTER) begin
        gap       = HOLD_CYCLES;
        hold_done = 1'b1;
      end else begin
        gap = burst_mode ? 0 : $urandom_range(0, 10);
      end
      @(negedge clk_i);
      if (gap > 0) begin
        result_if.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      result_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!result_if.valid) @(posedge clk_i);
      got.accepted       = result_if.accepted;
      got.launch         = result_if.launch;
      got.launch_length  = result_if.launch_length;
      got.tx_valid       = result_if.tx_valid;
      got.tx_byte        = result_if.tx_byte;
      got.pending        = result_if.pending;
      got.overflow_total = result_if.overflow_total;
      got.failure_total  = result_if.failure_total;
      board.check_word(got);
    end
  end

  initial begin : stimulus
    rst_ni              = 1'b0;
    item_if.valid       = 1'b0;
    item_if.action      = ACT_WRITE;
    item_if.write_byte  = '0;
    item_if.message_end = 1'b0;
    result_if.ready     = 1'b0;
    // Hold reset, then release it at a falling edge, away from the rising edge.
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    run_directed();

    // Random traffic in blocks; every third block runs without idle cycles.
    for (int blk = 0; blk < 9; blk++) begin
      burst_mode = (blk % 3 == 2);
      run_traffic(100);
    end
    burst_mode = 1'b0;

    fill_until_full();
    drain_ring();

    run_traffic(250);

    @(negedge clk_i);
    item_if.valid <= 1'b0;

    while (board.status_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("covered %0d words: %0d chunk launches, %0d bytes pulled",
             board.words_noted, board.launches, board.bytes_pulled);
    $display("ring filled to %0d, %0d overflows, %0d failures, %0d mismatches",
             RING_DEPTH_DEF - 1, board.overflow_cnt, board.fail_cnt, board.mismatches);
    if (board.mismatches == 0 && board.status_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
